@@ src/wheel_angle_pid_top_macros.svh @@
// ----------------------------------------------------------------------------
// wheel_angle_pid_top_macros.svh
// Assertion macros used by the steering controller checker.
// ----------------------------------------------------------------------------
`ifndef WHEEL_ANGLE_PID_TOP_MACROS_SVH
`define WHEEL_ANGLE_PID_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off while in reset.
`define WAP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while in reset.
`define WAP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/wap_pkg.sv @@
// ----------------------------------------------------------------------------
// wap_pkg
// Types and constants for the two-wheel steering PID controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wap_pkg;

    localparam int GAIN_FRAC_BITS = 8;
    localparam int INTEGRAL_WIDTH = 32;

    localparam int GAIN_W     = 16;
    localparam int ANGLE_W    = 9;
    localparam int ERR_W      = 9;
    localparam int DIFF_W     = 10;
    localparam int MAXV_W     = 10;
    localparam int VEL_W      = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // products and their sum
    localparam int PP_W  = GAIN_W + ERR_W;
    localparam int PI_W  = GAIN_W + INTEGRAL_WIDTH;
    localparam int PD_W  = GAIN_W + DIFF_W;
    localparam int ACC_W = PI_W + 2;
    localparam int SH_W  = ACC_W - GAIN_FRAC_BITS;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [MAXV_W-1:0] MAXV_RESET = MAXV_W'(200);

    localparam logic signed [DIFF_W-1:0] WRAP_HALF = DIFF_W'(180);
    localparam logic signed [DIFF_W-1:0] WRAP_FULL = DIFF_W'(360);
    localparam logic signed [ERR_W-1:0]  ON_BAND   = ERR_W'(2);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_KP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_KI      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_KD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_KP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_KI     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_KD     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VELOCITY = 3'd6;

    typedef logic signed [GAIN_W-1:0]         gain_t;
    typedef logic signed [ERR_W-1:0]          err_t;
    typedef logic signed [DIFF_W-1:0]         diff_t;
    typedef logic signed [INTEGRAL_WIDTH-1:0] integ_t;

    typedef struct packed {
        gain_t kp;
        gain_t ki;
        gain_t kd;
    } wap_gains_t;

    typedef struct packed {
        wap_gains_t              left_gains;
        wap_gains_t              right_gains;
        logic [MAXV_W-1:0]       max_velocity;
    } wap_cfg_t;

    // one classified beat handed from the front end to the back end
    typedef struct packed {
        logic   wheel;
        logic   on;
        err_t   err;
        diff_t  diff;
        integ_t integ;
    } wap_item_t;

endpackage

@@ src/wheel_angle_pid_top.sv @@
// Two-wheel steering PID controller. Each input beat names a wheel (0 left,
// 1 right) with a target and a measured angle in degrees; the wrapped error
// drives kp*e + ki*I + kd*(e - prev) with signed Q8.8 gains, floored to whole
// rpm, forced to zero within one degree of target and otherwise clamped to
// +/- max_velocity. The top motor gets that value, the bottom its negation.
// Throughput is one beat per clock while the queue has room: the front end
// wraps the error and updates that wheel's saturating integral and last
// error in the accept cycle; this read-modify-write of the per-wheel state
// is what lets beats for the same wheel follow each other back to back.
// From input accept to result valid a beat passes the queue, the product
// stage, the sum stage and the clamp into the output register. A
// 4-entry queue sits between front and back, so input stall rises only when
// that queue is full. Gains are picked at the product stage; write them only
// while the block is idle.
// ----------------------------------------------------------------------------
// wheel_angle_pid_top
// Top level: config registers, front end, queue, PID pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wheel_angle_pid_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_write,
    input  logic [wap_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wap_pkg::CFG_DATA_W-1:0]       cfg_data,
    // input channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 wheel_select,
    input  logic [wap_pkg::ANGLE_W-1:0]          setpoint_deg,
    input  logic [wap_pkg::ANGLE_W-1:0]          measured_deg,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 wheel_echo,
    output logic signed [wap_pkg::VEL_W-1:0]     top_velocity,
    output logic signed [wap_pkg::VEL_W-1:0]     bottom_velocity,
    output logic                                 on_target
);
    import wap_pkg::*;

    wap_cfg_t   cfg_reg;
    wap_item_t  front_item;
    wap_item_t  head_item;
    logic       in_accept;
    logic       q_full;
    logic       q_not_empty;
    logic       q_pop;

    // Config registers; an index past the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_gains   <= '0;
            cfg_reg.right_gains  <= '0;
            cfg_reg.max_velocity <= MAXV_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LEFT_KP:      cfg_reg.left_gains.kp  <= cfg_data;
                REG_LEFT_KI:      cfg_reg.left_gains.ki  <= cfg_data;
                REG_LEFT_KD:      cfg_reg.left_gains.kd  <= cfg_data;
                REG_RIGHT_KP:     cfg_reg.right_gains.kp <= cfg_data;
                REG_RIGHT_KI:     cfg_reg.right_gains.ki <= cfg_data;
                REG_RIGHT_KD:     cfg_reg.right_gains.kd <= cfg_data;
                REG_MAX_VELOCITY: cfg_reg.max_velocity   <= cfg_data[MAXV_W-1:0];
                default:          ;
            endcase
        end
    end

    // Input stall depends on queue occupancy alone.
    assign in_stall  = q_full;
    assign in_accept = in_valid && !in_stall;

    wap_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_accept),
        .wheel_select  (wheel_select),
        .setpoint_deg  (setpoint_deg),
        .measured_deg  (measured_deg),
        .item          (front_item)
    );

    wap_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_item (front_item),
        .pop       (q_pop),
        .head_item (head_item),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    wap_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .item            (head_item),
        .item_valid      (q_not_empty),
        .item_pop        (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .wheel_echo      (wheel_echo),
        .top_velocity    (top_velocity),
        .bottom_velocity (bottom_velocity),
        .on_target       (on_target)
    );

endmodule

@@ src/wap_front.sv @@
// ----------------------------------------------------------------------------
// wap_front
// Wraps the angle error and updates the per-wheel integral and last error.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wap_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic                         wheel_select,
    input  logic [wap_pkg::ANGLE_W-1:0]  setpoint_deg,
    input  logic [wap_pkg::ANGLE_W-1:0]  measured_deg,
    output wap_pkg::wap_item_t           item
);
    import wap_pkg::*;

    integ_t integ_reg [2];
    err_t   prev_reg  [2];

    diff_t                     raw;
    diff_t                     wrapped;
    err_t                      err;
    diff_t                     diff;
    logic [INTEGRAL_WIDTH:0]   sum_wide;
    integ_t                    sum_sat;

    localparam integ_t INTEG_MAX = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
    localparam integ_t INTEG_MIN = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};

    always_comb
    begin
        raw = $signed({1'b0, setpoint_deg}) - $signed({1'b0, measured_deg});
        // single wrap; -180 stays as is
        if (raw > WRAP_HALF)
        begin
            wrapped = raw - WRAP_FULL;
        end
        else if (raw < -WRAP_HALF)
        begin
            wrapped = raw + WRAP_FULL;
        end
        else
        begin
            wrapped = raw;
        end
        err  = wrapped[ERR_W-1:0];
        diff = DIFF_W'(err) - DIFF_W'(prev_reg[wheel_select]);

        sum_wide = (INTEGRAL_WIDTH+1)'(integ_reg[wheel_select]) + (INTEGRAL_WIDTH+1)'(err);
        if (sum_wide[INTEGRAL_WIDTH] != sum_wide[INTEGRAL_WIDTH-1])
        begin
            sum_sat = sum_wide[INTEGRAL_WIDTH] ? INTEG_MIN : INTEG_MAX;
        end
        else
        begin
            sum_sat = sum_wide[INTEGRAL_WIDTH-1:0];
        end

        item.wheel = wheel_select;
        item.on    = (err > -ON_BAND) && (err < ON_BAND);
        item.err   = err;
        item.diff  = diff;
        item.integ = sum_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg[0] <= '0;
            integ_reg[1] <= '0;
            prev_reg[0]  <= '0;
            prev_reg[1]  <= '0;
        end
        else if (accept)
        begin
            integ_reg[wheel_select] <= sum_sat;
            prev_reg[wheel_select]  <= err;
        end
    end

endmodule

@@ src/wap_queue.sv @@
// ----------------------------------------------------------------------------
// wap_queue
// Short FIFO that decouples the front end from the multiply pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wap_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  wap_pkg::wap_item_t  push_item,
    input  logic                pop,
    output wap_pkg::wap_item_t  head_item,
    output logic                not_empty,
    output logic                full
);
    import wap_pkg::*;

    wap_item_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign head_item = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ src/wap_back.sv @@
// ----------------------------------------------------------------------------
// wap_back
// Three-stage PID datapath: products, sum, fraction drop and clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wap_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  wap_pkg::wap_cfg_t                 cfg,
    input  wap_pkg::wap_item_t                item,
    input  logic                              item_valid,
    output logic                              item_pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              wheel_echo,
    output logic signed [wap_pkg::VEL_W-1:0]  top_velocity,
    output logic signed [wap_pkg::VEL_W-1:0]  bottom_velocity,
    output logic                              on_target
);
    import wap_pkg::*;

    // stage 1: products
    logic                     s1_valid_reg;
    logic                     s1_wheel_reg;
    logic                     s1_on_reg;
    logic signed [PP_W-1:0]   s1_pp_reg;
    logic signed [PI_W-1:0]   s1_pi_reg;
    logic signed [PD_W-1:0]   s1_pd_reg;
    // stage 2: sum
    logic                     s2_valid_reg;
    logic                     s2_wheel_reg;
    logic                     s2_on_reg;
    logic signed [ACC_W-1:0]  s2_acc_reg;
    // stage 3: output register
    logic                     s3_valid_reg;
    logic                     s3_wheel_reg;
    logic                     s3_on_reg;
    logic signed [VEL_W-1:0]  s3_top_reg;
    logic signed [VEL_W-1:0]  s3_bot_reg;

    logic s1_ready, s2_ready, s3_ready;

    wap_gains_t              gains;
    logic signed [SH_W-1:0]  shifted;
    logic signed [SH_W-1:0]  lim;
    logic signed [SH_W-1:0]  vel;

    assign s3_ready = !s3_valid_reg || !out_stall;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign item_pop = item_valid && s1_ready;

    assign gains = item.wheel ? cfg.right_gains : cfg.left_gains;

    always_comb
    begin
        shifted = SH_W'(s2_acc_reg >>> GAIN_FRAC_BITS);
        lim     = $signed(SH_W'(cfg.max_velocity));
        if (s2_on_reg)
        begin
            vel = '0;
        end
        else if (shifted > lim)
        begin
            vel = lim;
        end
        else if (shifted < -lim)
        begin
            vel = -lim;
        end
        else
        begin
            vel = shifted;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            s1_wheel_reg <= item.wheel;
            s1_on_reg    <= item.on;
            s1_pp_reg    <= PP_W'(gains.kp) * PP_W'(item.err);
            s1_pi_reg    <= PI_W'(gains.ki) * PI_W'(item.integ);
            s1_pd_reg    <= PD_W'(gains.kd) * PD_W'(item.diff);
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_wheel_reg <= s1_wheel_reg;
            s2_on_reg    <= s1_on_reg;
            s2_acc_reg   <= ACC_W'(s1_pp_reg) + ACC_W'(s1_pi_reg) + ACC_W'(s1_pd_reg);
        end
        if (s2_valid_reg && s3_ready)
        begin
            s3_wheel_reg <= s2_wheel_reg;
            s3_on_reg    <= s2_on_reg;
            s3_top_reg   <= vel[VEL_W-1:0];
            s3_bot_reg   <= VEL_W'(-vel);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= item_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    assign out_valid       = s3_valid_reg;
    assign wheel_echo      = s3_wheel_reg;
    assign on_target       = s3_on_reg;
    assign top_velocity    = s3_top_reg;
    assign bottom_velocity = s3_bot_reg;

endmodule

@@ src/wap_checker.sv @@
// ----------------------------------------------------------------------------
// wap_checker
// Port-level checks on the steering controller result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "wheel_angle_pid_top_macros.svh"

module wap_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic                              wheel_echo,
    input  logic signed [wap_pkg::VEL_W-1:0]  top_velocity,
    input  logic signed [wap_pkg::VEL_W-1:0]  bottom_velocity,
    input  logic                              on_target
);
    import wap_pkg::*;

    // stalled result beat holds
    `WAP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(top_velocity) && $stable(wheel_echo) && $stable(on_target), "result changed while stalled")

    // bottom motor is the exact negation of top
    `WAP_ASSERT_NOW(a_bottom_neg, out_valid, VEL_W'(top_velocity + bottom_velocity) == '0, "bottom is not -top")

    // on target means zero drive
    `WAP_ASSERT_NOW(a_on_zero, out_valid && on_target, top_velocity == '0, "drive not zero on target")

    // clamp never reaches the most negative code
    `WAP_ASSERT_NOW(a_no_minneg, out_valid, top_velocity != {1'b1, {(VEL_W-1){1'b0}}}, "drive at most negative code")

endmodule

bind wheel_angle_pid_top wap_checker u_wap_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-wheel steering PID controller.
// A tracker predicts each wheel's drive command as input beats are
// accepted and matches every result beat against the oldest prediction.
// The run has a directed set of angle corner cases and four random phases,
// each with its own gain setting; the first three also set their own mix
// of sender and receiver idling. One phase also holds the result side off
// long enough to fill the block.
// ----------------------------------------------------------------------------

import wap_pkg::*;

typedef struct {
    logic                    wheel;
    logic signed [VEL_W-1:0] top;
    logic signed [VEL_W-1:0] bottom;
    logic                    on;
} drive_t;

// Tracks gains, per-wheel integral and last error; queues the drive
// commands that are due in accept order.
class drive_tracker;
    gain_t             kp[2];
    gain_t             ki[2];
    gain_t             kd[2];
    logic [MAXV_W-1:0] vmax;
    integ_t            integ[2];
    err_t              prev_err[2];
    drive_t            due_drives[$];
    int                fault_count;

    function void power_on();
        for (int i = 0; i < 2; i++)
        begin
            kp[i]       = '0;
            ki[i]       = '0;
            kd[i]       = '0;
            integ[i]    = '0;
            prev_err[i] = '0;
        end
        vmax        = MAXV_RESET;
        fault_count = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_LEFT_KP:      kp[0] = gain_t'(data);
            REG_LEFT_KI:      ki[0] = gain_t'(data);
            REG_LEFT_KD:      kd[0] = gain_t'(data);
            REG_RIGHT_KP:     kp[1] = gain_t'(data);
            REG_RIGHT_KI:     ki[1] = gain_t'(data);
            REG_RIGHT_KD:     kd[1] = gain_t'(data);
            REG_MAX_VELOCITY: vmax  = data[MAXV_W-1:0];
            default: ;
        endcase
    endfunction

    function void take_command(logic w, logic [ANGLE_W-1:0] tgt, logic [ANGLE_W-1:0] cur);
        longint imax;
        longint imin;
        longint sum;
        longint acc;
        longint v;
        longint lim;
        int     e;
        int     d;
        drive_t due;
        imax = (longint'(1) <<< (INTEGRAL_WIDTH - 1)) - 1;
        imin = -imax - 1;
        e = int'(tgt) - int'(cur);
        // single wrap into the half-turn window; -180 is left alone
        if (e > int'(WRAP_HALF))
            e = e - int'(WRAP_FULL);
        if (e < -int'(WRAP_HALF))
            e = e + int'(WRAP_FULL);
        d   = e - int'(prev_err[w]);
        sum = longint'(integ[w]) + e;
        if (sum > imax)
            sum = imax;
        if (sum < imin)
            sum = imin;
        integ[w]    = integ_t'(sum);
        prev_err[w] = err_t'(e);
        acc = longint'(kp[w]) * e + longint'(ki[w]) * sum + longint'(kd[w]) * d;
        v   = acc >>> GAIN_FRAC_BITS;   // floor
        lim = longint'(vmax);
        due.on = (e > -int'(ON_BAND)) && (e < int'(ON_BAND));
        if (due.on)
            v = 0;
        else if (v > lim)
            v = lim;
        else if (v < -lim)
            v = -lim;
        due.wheel  = w;
        due.top    = VEL_W'(v);
        due.bottom = VEL_W'(-v);
        due_drives.push_back(due);
    endfunction

    function void flag(string field, logic signed [31:0] want, logic signed [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fault_count++;
        end
    endfunction

    function void match_drive(logic w, logic signed [VEL_W-1:0] top,
                              logic signed [VEL_W-1:0] bottom, logic on);
        drive_t want;
        if (due_drives.size() == 0)
        begin
            $error("drive beat with nothing pending: wheel %0d top %0d", w, top);
            fault_count++;
            return;
        end
        want = due_drives.pop_front();
        flag("wheel_echo", {31'd0, want.wheel}, {31'd0, w});
        flag("top_velocity", want.top, top);
        flag("bottom_velocity", want.bottom, bottom);
        flag("on_target", {31'd0, want.on}, {31'd0, on});
    endfunction

    function int pending();
        return due_drives.size();
    endfunction
endclass

module testbench;

    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 8;     // pipeline is 3 deep, leave margin
    localparam int HOLD_CYCLES  = 64;    // long enough to fill queue and pipe
    localparam int QUIET_LIMIT  = 2000;  // cycles with no beat at all

    logic                           clk             = 1'b0;
    logic                           rst_n           = 1'b0;
    logic                           cfg_write       = 1'b0;
    logic [CFG_IDX_W-1:0]           cfg_index       = '0;
    logic [CFG_DATA_W-1:0]          cfg_data        = '0;
    logic                           in_valid        = 1'b0;
    logic                           in_stall;
    logic                           wheel_select    = 1'b0;
    logic [ANGLE_W-1:0]             setpoint_deg    = '0;
    logic [ANGLE_W-1:0]             measured_deg    = '0;
    logic                           out_valid;
    logic                           out_stall       = 1'b0;
    logic                           wheel_echo;
    logic signed [VEL_W-1:0]        top_velocity;
    logic signed [VEL_W-1:0]        bottom_velocity;
    logic                           on_target;

    drive_tracker tracker;

    // idling mix, set per phase by the sequencer
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // hold-off requests: the sequencer bumps hold_asks, the receiver
    // notices the change and counts the stretch down on its own
    int hold_asks     = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    wheel_angle_pid_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .wheel_select    (wheel_select),
        .setpoint_deg    (setpoint_deg),
        .measured_deg    (measured_deg),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .wheel_echo      (wheel_echo),
        .top_velocity    (top_velocity),
        .bottom_velocity (bottom_velocity),
        .on_target       (on_target)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Result side. Sampled at the rising edge, so the values seen are the
    // ones that were on the wires during the cycle that just ended. The
    // stall for the next cycle is decided here too, one assignment a step.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                tracker.match_drive(wheel_echo, top_velocity, bottom_velocity, on_target);
            if (hold_seen != hold_asks)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Watchdog: a correct block never goes this long without moving a beat,
    // the long hold-off and the drain waits included.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender. Optional idle cycles first, then the beat is held until the
    // block takes it. Each step sees a single assignment to in_valid, so a
    // back-to-back beat never drops valid for a moment.
    // ------------------------------------------------------------------
    task automatic send_beat(input logic w, input int tgt, input int cur);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        wheel_select  <= w;
        setpoint_deg  <= ANGLE_W'(tgt);
        measured_deg  <= ANGLE_W'(cur);
        do
            @(posedge clk);
        while (in_stall);
        tracker.take_command(w, ANGLE_W'(tgt), ANGLE_W'(cur));
    endtask

    // Wait until every pending drive has come back, then let the pipe go
    // quiet before any gain is touched.
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        tracker.set_reg(idx, data);
    endtask

    task automatic load_gains(input gain_t lkp, input gain_t lki, input gain_t lkd,
                              input gain_t rkp, input gain_t rki, input gain_t rkd,
                              input logic [CFG_DATA_W-1:0] vmax_word);
        cfg_put(REG_LEFT_KP, lkp);
        cfg_put(REG_LEFT_KI, lki);
        cfg_put(REG_LEFT_KD, lkd);
        cfg_put(REG_RIGHT_KP, rkp);
        cfg_put(REG_RIGHT_KI, rki);
        cfg_put(REG_RIGHT_KD, rkd);
        cfg_put(REG_MAX_VELOCITY, vmax_word);
        cfg_write <= 1'b0;
    endtask

    function automatic gain_t rand_gain(int span);
        return gain_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // Random settings with gains small enough that the output is not
    // pinned to the clamp all the time.
    task automatic load_moderate(input int vmax);
        load_gains(rand_gain(1024), rand_gain(24), rand_gain(1024),
                   rand_gain(1024), rand_gain(24), rand_gain(1024), CFG_DATA_W'(vmax));
    endtask

    // Mostly in-range angles; a fifth of the beats sit within two degrees
    // of target (on-target band and its edge), a tenth use the whole field.
    task automatic run_random(input int count, input int hold_at);
        int  a;
        int  b;
        logic w;
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
                hold_asks = hold_asks + 1;
            w = 1'($urandom_range(0, 1));
            a = $urandom_range(0, 359);
            case ($urandom_range(0, 9))
                0:
                begin
                    a = $urandom_range(0, 511);
                    b = $urandom_range(0, 511);
                end
                1, 2: b = (a + 358 + $urandom_range(0, 4)) % 360;
                default: b = $urandom_range(0, 359);
            endcase
            send_beat(w, b, a);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial
    begin
        tracker = new;
        tracker.power_on();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: wrap edges, on-target band, angles past 359
        load_gains(16'sh0100, 16'sh0010, 16'sh0080,
                   -16'sh0180, -16'sh0008, 16'sh0040, 16'd200);
        send_beat(1'b0, 0, 0);        // dead on
        send_beat(1'b0, 1, 0);        // +1, inside band
        send_beat(1'b0, 0, 1);        // -1, inside band
        send_beat(1'b0, 2, 0);        // +2, just outside
        send_beat(1'b0, 0, 2);        // -2, just outside
        send_beat(1'b0, 180, 0);      // +180 stays
        send_beat(1'b0, 181, 0);      // wraps to -179
        send_beat(1'b0, 0, 180);      // -180 stays
        send_beat(1'b0, 0, 181);      // wraps to +179
        send_beat(1'b1, 359, 0);      // wraps to -1
        send_beat(1'b1, 0, 359);      // wraps to +1
        send_beat(1'b1, 511, 0);      // all-ones target
        send_beat(1'b1, 0, 511);      // all-ones measured
        send_beat(1'b1, 511, 511);
        send_beat(1'b1, 359, 359);
        send_beat(1'b1, 256, 100);
        send_beat(1'b0, 90, 270);     // exactly -180
        send_beat(1'b1, 270, 90);     // exactly +180
        send_beat(1'b0, 300, 10);
        send_beat(1'b1, 10, 300);
        settle();

        // phase A: slow sender, slower receiver
        load_moderate(600);
        send_idle_pct = 35;
        recv_idle_pct = 75;
        run_random(220, -1);
        settle();

        // phase B: gains at their extremes, clamp register with junk above
        // its ten bits (reads back as 1023)
        load_gains(16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                   16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF);
        send_idle_pct = 75;
        recv_idle_pct = 35;
        run_random(200, -1);
        settle();

        // phase C: full rate, with one long receiver hold-off
        load_moderate($urandom_range(1, 599));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(250, 20);
        settle();

        // phase D: any gain, zero clamp
        load_gains(gain_t'($urandom), gain_t'($urandom), gain_t'($urandom),
                   gain_t'($urandom), gain_t'($urandom), gain_t'($urandom), 16'd0);
        run_random(110, -1);
        settle();

        if (tracker.fault_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
